FILE: rtl/core/preemptive_priority_task_queue_top_macros.svh
// assertion macros for the priority task queue
`ifndef PREEMPTIVE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PPQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppq assertion failed");
`define PPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppq assertion failed");
`else
`define PPQ_ASSERT(label, prop)
`define PPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/ppq_pkg.sv
// types, constants and codes shared by the priority task queue
package ppq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NEST_DEPTH  = 16;
    localparam int HANDLE_BITS = 16;

    localparam int PRIO_W  = 10;
    localparam int HFIELD_W = 16;
    localparam int HW      = (HANDLE_BITS < HFIELD_W) ? HANDLE_BITS : HFIELD_W;
    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int NIDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int NCNT_W  = $clog2(NEST_DEPTH + 1);

    localparam logic [CNT_W-1:0]  QUEUE_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [NCNT_W-1:0] NEST_FULL  = NCNT_W'(NEST_DEPTH);
    localparam logic [PRIO_W-1:0] IDLE_LEVEL = PRIO_W'(999);

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RUN      = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_NEST_OVF = 3'd4;
    localparam logic [2:0] ST_NO_NEST  = 3'd5;

    typedef struct packed {
        logic [1:0]          kind;
        logic [PRIO_W-1:0]   task_priority;
        logic [HFIELD_W-1:0] task_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [HFIELD_W-1:0] run_handle;
        logic [PRIO_W-1:0]   run_priority;
        logic [4:0]          queued_count;
        logic [PRIO_W-1:0]   running_priority;
    } rsp_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [HW-1:0]     handle;
    } q_entry_t;

    typedef struct packed {
        logic              we;
        logic [QIDX_W-1:0] waddr;
        q_entry_t          wdata;
        logic [QIDX_W-1:0] raddr;
    } q_req_t;

    typedef struct packed {
        logic              we;
        logic [NIDX_W-1:0] waddr;
        logic [PRIO_W-1:0] wdata;
        logic [NIDX_W-1:0] raddr;
    } s_req_t;

endpackage

FILE: rtl/core/ppq_ram.sv
// generic single write port ram with registered read
module ppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ppq_seq.sv
// sequencer: sorted insert, head dispatch and nest stack over one shared compare
module ppq_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ppq_pkg::req_t     req,
    output ppq_pkg::q_req_t   q_req,
    input  ppq_pkg::q_entry_t q_rdata,
    output ppq_pkg::s_req_t   s_req,
    input  logic [ppq_pkg::PRIO_W-1:0] s_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output ppq_pkg::rsp_t     res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_CMP  = 3'd1;
    localparam logic [2:0] S_ADD_PUT  = 3'd2;
    localparam logic [2:0] S_DONE_RD  = 3'd3;
    localparam logic [2:0] S_CHK_EVAL = 3'd4;
    localparam logic [2:0] S_POP      = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [ppq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ppq_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [ppq_pkg::NCNT_W-1:0]   nest_reg, nest_next;
    logic [ppq_pkg::PRIO_W-1:0]   level_reg, level_next;
    ppq_pkg::q_entry_t            new_reg, new_next;
    ppq_pkg::q_entry_t            run_reg, run_next;
    logic [2:0]                   status_reg, status_next;

    logic [ppq_pkg::PRIO_W-1:0]   cmp_a, cmp_b;
    logic                         lt;
    logic [ppq_pkg::CNT_W-1:0]    cnt_dec, idx_dec, idx_dec2, idx_inc;
    logic [ppq_pkg::NCNT_W-1:0]   nest_dec;

    // shared comparator: insert scan asks new < entry, dispatch asks head < level
    always_comb
    begin
        if (state_reg == S_ADD_CMP)
        begin
            cmp_a = new_reg.prio;
            cmp_b = q_rdata.prio;
        end
        else
        begin
            cmp_a = q_rdata.prio;
            cmp_b = level_reg;
        end
    end

    assign lt       = cmp_a < cmp_b;
    assign cnt_dec  = count_reg - ppq_pkg::CNT_W'(1);
    assign idx_dec  = idx_reg - ppq_pkg::CNT_W'(1);
    assign idx_dec2 = idx_reg - ppq_pkg::CNT_W'(2);
    assign idx_inc  = idx_reg + ppq_pkg::CNT_W'(1);
    assign nest_dec = nest_reg - ppq_pkg::NCNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        nest_next   = nest_reg;
        level_next  = level_reg;
        new_next    = new_reg;
        run_next    = run_reg;
        status_next = status_reg;
        q_req       = '0;
        s_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    new_next.prio   = req.task_priority;
                    new_next.handle = req.task_handle[ppq_pkg::HW-1:0];
                    run_next        = '0;
                    unique case (req.kind)
                        ppq_pkg::KIND_ADD:
                        begin
                            if (count_reg == ppq_pkg::QUEUE_FULL)
                            begin
                                status_next = ppq_pkg::ST_FULL;
                                state_next  = S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                q_req.we           = 1'b1;
                                q_req.waddr        = '0;
                                q_req.wdata.prio   = req.task_priority;
                                q_req.wdata.handle = req.task_handle[ppq_pkg::HW-1:0];
                                count_next         = ppq_pkg::CNT_W'(1);
                                status_next        = ppq_pkg::ST_ADDED;
                                state_next         = S_OUT;
                            end
                            else
                            begin
                                idx_next    = count_reg;
                                q_req.raddr = cnt_dec[ppq_pkg::QIDX_W-1:0];
                                state_next  = S_ADD_CMP;
                            end
                        end
                        ppq_pkg::KIND_CHECK:
                        begin
                            q_req.raddr = '0;
                            state_next  = S_CHK_EVAL;
                        end
                        ppq_pkg::KIND_DONE:
                        begin
                            if (nest_reg == '0)
                            begin
                                status_next = ppq_pkg::ST_NO_NEST;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                nest_next   = nest_dec;
                                s_req.raddr = nest_dec[ppq_pkg::NIDX_W-1:0];
                                q_req.raddr = '0;
                                state_next  = S_DONE_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ppq_pkg::ST_NONE;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_ADD_CMP:
            begin
                // walk from the tail, moving back every entry with a higher number than the new one
                if (lt)
                begin
                    q_req.we    = 1'b1;
                    q_req.waddr = idx_reg[ppq_pkg::QIDX_W-1:0];
                    q_req.wdata = q_rdata;
                    idx_next    = idx_dec;
                    if (idx_reg == ppq_pkg::CNT_W'(1))
                    begin
                        state_next = S_ADD_PUT;
                    end
                    else
                    begin
                        q_req.raddr = idx_dec2[ppq_pkg::QIDX_W-1:0];
                    end
                end
                else
                begin
                    q_req.we    = 1'b1;
                    q_req.waddr = idx_reg[ppq_pkg::QIDX_W-1:0];
                    q_req.wdata = new_reg;
                    count_next  = count_reg + ppq_pkg::CNT_W'(1);
                    status_next = ppq_pkg::ST_ADDED;
                    state_next  = S_OUT;
                end
            end
            S_ADD_PUT:
            begin
                q_req.we    = 1'b1;
                q_req.waddr = '0;
                q_req.wdata = new_reg;
                count_next  = count_reg + ppq_pkg::CNT_W'(1);
                status_next = ppq_pkg::ST_ADDED;
                state_next  = S_OUT;
            end
            S_DONE_RD:
            begin
                level_next  = s_rdata;
                q_req.raddr = '0;
                state_next  = S_CHK_EVAL;
            end
            S_CHK_EVAL:
            begin
                if (count_reg == '0 || !lt)
                begin
                    status_next = ppq_pkg::ST_NONE;
                    state_next  = S_OUT;
                end
                else if (nest_reg == ppq_pkg::NEST_FULL)
                begin
                    status_next = ppq_pkg::ST_NEST_OVF;
                    state_next  = S_OUT;
                end
                else
                begin
                    s_req.we    = 1'b1;
                    s_req.waddr = nest_reg[ppq_pkg::NIDX_W-1:0];
                    s_req.wdata = level_reg;
                    nest_next   = nest_reg + ppq_pkg::NCNT_W'(1);
                    level_next  = q_rdata.prio;
                    run_next    = q_rdata;
                    status_next = ppq_pkg::ST_RUN;
                    if (count_reg == ppq_pkg::CNT_W'(1))
                    begin
                        count_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next    = ppq_pkg::CNT_W'(1);
                        q_req.raddr = ppq_pkg::QIDX_W'(1);
                        state_next  = S_POP;
                    end
                end
            end
            S_POP:
            begin
                // close the gap left by the head, one entry a cycle
                q_req.we    = 1'b1;
                q_req.waddr = idx_dec[ppq_pkg::QIDX_W-1:0];
                q_req.wdata = q_rdata;
                if (idx_inc == count_reg)
                begin
                    count_next = cnt_dec;
                    state_next = S_OUT;
                end
                else
                begin
                    q_req.raddr = idx_inc[ppq_pkg::QIDX_W-1:0];
                    idx_next    = idx_inc;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            nest_reg  <= '0;
            level_reg <= ppq_pkg::IDLE_LEVEL;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nest_reg  <= nest_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        new_reg    <= new_next;
        run_reg    <= run_next;
        status_reg <= status_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    always_comb
    begin
        res.status           = status_reg;
        res.run_handle       = ppq_pkg::HFIELD_W'(run_reg.handle);
        res.run_priority     = run_reg.prio;
        res.queued_count     = 5'(count_reg);
        res.running_priority = level_reg;
    end

endmodule

FILE: rtl/core/preemptive_priority_task_queue_top.sv
// top level of the preemptive priority task queue
//
//  channel | handshake           | word
//  --------+---------------------+--------------------------------------------
//  req     | req_valid/req_ready | kind, task_priority, task_handle
//  rsp     | rsp_valid/rsp_ready | status, run_handle, run_priority,
//          |                     | queued_count, running_priority
//
// one word in flight: req_ready is high only while the sequencer is idle
// add: into an empty queue it is written from idle, else the scan moves entries back first
// check: compare head with level, pop it, move the rest forward; done restores level first
// every pass reuses one priority comparator and one read port of the queue ram
// the result register lets a new word in while rsp waits on rsp_ready
// reset empties the queue and nest stack and sets running level to 999
`include "preemptive_priority_task_queue_top_macros.svh"

module preemptive_priority_task_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ppq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ppq_pkg::rsp_t  rsp
);

    ppq_pkg::q_req_t            q_req;
    ppq_pkg::q_entry_t          q_rdata;
    ppq_pkg::s_req_t            s_req;
    logic [ppq_pkg::PRIO_W-1:0] s_rdata;
    logic                       res_valid;
    logic                       res_ready;
    ppq_pkg::rsp_t              res;

    logic                       out_valid_reg;
    ppq_pkg::rsp_t              out_reg;

    ppq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_req     (q_req),
        .q_rdata   (q_rdata),
        .s_req     (s_req),
        .s_rdata   (s_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ppq_ram #(
        .WIDTH ($bits(ppq_pkg::q_entry_t)),
        .DEPTH (ppq_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_req.we),
        .waddr (q_req.waddr),
        .wdata (q_req.wdata),
        .raddr (q_req.raddr),
        .rdata (q_rdata)
    );

    ppq_ram #(
        .WIDTH (ppq_pkg::PRIO_W),
        .DEPTH (ppq_pkg::NEST_DEPTH)
    ) u_nest_ram (
        .clk   (clk),
        .we    (s_req.we),
        .waddr (s_req.waddr),
        .wdata (s_req.wdata),
        .raddr (s_req.raddr),
        .rdata (s_rdata)
    );

    assign res_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `PPQ_ASSERT(a_run_sets_level, (rsp_valid && rsp.status == ppq_pkg::ST_RUN) |-> (rsp.running_priority == rsp.run_priority))
    `PPQ_ASSERT(a_idle_fields_zero, (rsp_valid && rsp.status != ppq_pkg::ST_RUN) |-> (rsp.run_handle == '0 && rsp.run_priority == '0))
    `PPQ_ASSERT(a_no_nest_idle_level, (rsp_valid && rsp.status == ppq_pkg::ST_NO_NEST) |-> (rsp.running_priority == ppq_pkg::IDLE_LEVEL))
    `PPQ_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res))

endmodule

FILE: bench/preemptive_priority_task_queue_top_tb.sv
// self-checking testbench for the preemptive priority task queue top level
`timescale 1ns / 100ps

module preemptive_priority_task_queue_top_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int WORD_TARGET = 420;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // mirror of the sorted queue and nesting stack, predicting one response per word
    class task_queue_mirror;
        logic [ppq_pkg::PRIO_W-1:0] q_prio [ppq_pkg::QUEUE_DEPTH];
        logic [ppq_pkg::HW-1:0]     q_handle [ppq_pkg::QUEUE_DEPTH];
        int                         q_len;
        logic [ppq_pkg::PRIO_W-1:0] level;
        logic [ppq_pkg::PRIO_W-1:0] saved [ppq_pkg::NEST_DEPTH];
        int                         depth;
        ppq_pkg::rsp_t              awaited [$];
        int                         errors;
        int                         words_in;
        int                         status_seen [8];

        function new();
            q_len = 0;
            level = ppq_pkg::IDLE_LEVEL;
            depth = 0;
            errors = 0;
            words_in = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // pop the head if it beats the running level
        function logic [2:0] dispatch(output logic [ppq_pkg::HW-1:0] h,
                                      output logic [ppq_pkg::PRIO_W-1:0] p);
            h = '0;
            p = '0;
            if (q_len == 0 || q_prio[0] >= level)
                return ppq_pkg::ST_NONE;
            if (depth >= ppq_pkg::NEST_DEPTH)
                return ppq_pkg::ST_NEST_OVF;
            saved[depth] = level;
            depth++;
            h = q_handle[0];
            p = q_prio[0];
            level = p;
            for (int i = 1; i < q_len; i++)
            begin
                q_prio[i-1] = q_prio[i];
                q_handle[i-1] = q_handle[i];
            end
            q_len--;
            return ppq_pkg::ST_RUN;
        endfunction

        function void record_request(ppq_pkg::req_t w);
            ppq_pkg::rsp_t              r;
            logic [ppq_pkg::HW-1:0]     h;
            logic [ppq_pkg::PRIO_W-1:0] p;
            int                         pos;
            r = '0;
            h = '0;
            p = '0;
            r.status = ppq_pkg::ST_NONE;
            case (w.kind)
                ppq_pkg::KIND_ADD:
                begin
                    if (q_len >= ppq_pkg::QUEUE_DEPTH)
                        r.status = ppq_pkg::ST_FULL;
                    else
                    begin
                        // stable insert: after every entry of equal or lower number
                        pos = 0;
                        while (pos < q_len && q_prio[pos] <= w.task_priority)
                            pos++;
                        for (int i = q_len; i > pos; i--)
                        begin
                            q_prio[i] = q_prio[i-1];
                            q_handle[i] = q_handle[i-1];
                        end
                        q_prio[pos] = w.task_priority;
                        q_handle[pos] = w.task_handle[ppq_pkg::HW-1:0];
                        q_len++;
                        r.status = ppq_pkg::ST_ADDED;
                    end
                end
                ppq_pkg::KIND_CHECK:
                    r.status = dispatch(h, p);
                ppq_pkg::KIND_DONE:
                begin
                    if (depth == 0)
                        r.status = ppq_pkg::ST_NO_NEST;
                    else
                    begin
                        depth--;
                        level = saved[depth];
                        r.status = dispatch(h, p);
                    end
                end
                default:
                    r.status = ppq_pkg::ST_NONE;
            endcase
            if (r.status == ppq_pkg::ST_RUN)
            begin
                r.run_handle = ppq_pkg::HFIELD_W'(h);
                r.run_priority = p;
            end
            r.queued_count = 5'(q_len);
            r.running_priority = level;
            awaited.push_back(r);
            words_in++;
        endfunction

        function void check_response(ppq_pkg::rsp_t got);
            ppq_pkg::rsp_t want;
            status_seen[got.status]++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected response word: status %0d handle %h prio %0d",
                             got.status, got.run_handle, got.run_priority);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.run_handle !== want.run_handle ||
                got.run_priority !== want.run_priority ||
                got.queued_count !== want.queued_count ||
                got.running_priority !== want.running_priority)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch: expected status %0d handle %h prio %0d count %0d level %0d",
                             want.status, want.run_handle, want.run_priority,
                             want.queued_count, want.running_priority);
                    $display("          actual   status %0d handle %h prio %0d count %0d level %0d",
                             got.status, got.run_handle, got.run_priority,
                             got.queued_count, got.running_priority);
                end
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    ppq_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    ppq_pkg::rsp_t  rsp;

    task_queue_mirror sb;
    bit  calm = 1'b0;
    bit  rsp_fired = 1'b0;
    int  rsp_hold = 0;
    int  idle_cycles = 0;
    int  sent = 0;

    preemptive_priority_task_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // small values give plenty of ties; a few land around the idle level
    function automatic logic [ppq_pkg::PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ppq_pkg::PRIO_W'($urandom_range(0, 15));
            6, 7:             return ppq_pkg::PRIO_W'($urandom_range(0, 1023));
            8:                return ppq_pkg::PRIO_W'($urandom_range(990, 1023));
            default:          return $urandom_range(0, 1) ? {ppq_pkg::PRIO_W{1'b1}}
                                                          : {ppq_pkg::PRIO_W{1'b0}};
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic [1:0] kind,
                             input logic [ppq_pkg::PRIO_W-1:0] prio,
                             input logic [ppq_pkg::HFIELD_W-1:0] handle);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{kind: kind, task_priority: prio, task_handle: handle};
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.awaited.size() > 0)
            @(negedge clk);
    endtask

    task automatic send_mixed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            send_word(ppq_pkg::KIND_ADD, pick_priority(), ppq_pkg::HFIELD_W'($urandom));
        else if (roll < 70)
            send_word(ppq_pkg::KIND_CHECK, ppq_pkg::PRIO_W'($urandom),
                      ppq_pkg::HFIELD_W'($urandom));
        else if (roll < 95)
            send_word(ppq_pkg::KIND_DONE, ppq_pkg::PRIO_W'($urandom),
                      ppq_pkg::HFIELD_W'($urandom));
        else
            send_word(KIND_UNUSED, ppq_pkg::PRIO_W'($urandom), ppq_pkg::HFIELD_W'($urandom));
    endtask

    task automatic fill_queue();
        int extra;
        extra = $urandom_range(1, 3);
        while (sb.q_len < ppq_pkg::QUEUE_DEPTH)
            send_word(ppq_pkg::KIND_ADD, pick_priority(), ppq_pkg::HFIELD_W'($urandom));
        repeat (extra)
            send_word(ppq_pkg::KIND_ADD, pick_priority(), ppq_pkg::HFIELD_W'($urandom));
    endtask

    // add a task just below the running level and dispatch it, on past stack overflow
    task automatic nest_chain();
        logic [ppq_pkg::PRIO_W-1:0] p;
        int steps;
        steps = 0;
        while (sb.depth <= ppq_pkg::NEST_DEPTH && sb.level > 0 && steps < 40)
        begin
            p = sb.level - ppq_pkg::PRIO_W'($urandom_range(1, (sb.level < 8) ? sb.level : 8));
            if (sb.q_len < ppq_pkg::QUEUE_DEPTH)
                send_word(ppq_pkg::KIND_ADD, p, ppq_pkg::HFIELD_W'($urandom));
            send_word(ppq_pkg::KIND_CHECK, ppq_pkg::PRIO_W'($urandom),
                      ppq_pkg::HFIELD_W'($urandom));
            if (sb.depth == ppq_pkg::NEST_DEPTH && steps > 0 &&
                sb.status_seen[ppq_pkg::ST_NEST_OVF] > 0 && $urandom_range(0, 1))
                break;
            steps++;
        end
    endtask

    task automatic unwind();
        int n;
        n = sb.depth + 1;
        repeat (n)
        begin
            send_word(ppq_pkg::KIND_DONE, ppq_pkg::PRIO_W'($urandom),
                      ppq_pkg::HFIELD_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_word(ppq_pkg::KIND_CHECK, ppq_pkg::PRIO_W'($urandom),
                          ppq_pkg::HFIELD_W'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.record_request(req);
            if (rsp_valid && rsp_ready)
            begin
                sb.check_response(rsp);
                rsp_fired = 1'b1;
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
                         STALL_LIMIT, sb.awaited.size());
                $display("preemptive_priority_task_queue_top_tb: done, errors");
                $finish;
            end
        end
    end

    // receiver may stall for a random gap after each response word
    always @(negedge clk)
    begin
        if (rsp_fired)
        begin
            rsp_fired = 1'b0;
            rsp_hold = pick_gap();
        end
        if (rsp_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold--;
        end
        else
            rsp_ready <= 1'b1;
    end

    initial
    begin
        int phase_roll;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty cases, extremes, stable ties, nested dispatch and restore
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_CHECK, 10'd1023, 16'hffff);
        send_word(KIND_UNUSED, 10'd1023, 16'hffff);
        send_word(ppq_pkg::KIND_ADD, 10'd1023, 16'h0000);
        send_word(ppq_pkg::KIND_ADD, 10'd0, 16'hffff);
        send_word(ppq_pkg::KIND_ADD, 10'd5, 16'h0001);
        send_word(ppq_pkg::KIND_ADD, 10'd5, 16'h0002);
        send_word(ppq_pkg::KIND_ADD, 10'd5, 16'h0003);
        send_word(ppq_pkg::KIND_ADD, 10'd999, 16'haaaa);
        send_word(ppq_pkg::KIND_ADD, 10'd998, 16'h5555);
        send_word(ppq_pkg::KIND_CHECK, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_CHECK, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_CHECK, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        send_word(ppq_pkg::KIND_DONE, 10'd0, 16'h0000);
        drain();

        // deep nesting first while the level is high, then a full queue
        nest_chain();
        unwind();
        fill_queue();
        drain();

        while (sent < WORD_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            phase_roll = $urandom_range(0, 9);
            if (phase_roll < 5)
                repeat ($urandom_range(10, 30)) send_mixed();
            else if (phase_roll < 7)
                fill_queue();
            else if (phase_roll < 9)
            begin
                nest_chain();
                unwind();
            end
            else
            begin
                unwind();
                drain();
            end
        end
        calm = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d request words: %0d added, %0d refused on full queue, %0d dispatched",
                 sb.words_in, sb.status_seen[ppq_pkg::ST_ADDED],
                 sb.status_seen[ppq_pkg::ST_FULL], sb.status_seen[ppq_pkg::ST_RUN]);
        $display("  %0d nothing runnable, %0d nest overflows, %0d finishes without nesting",
                 sb.status_seen[ppq_pkg::ST_NONE], sb.status_seen[ppq_pkg::ST_NEST_OVF],
                 sb.status_seen[ppq_pkg::ST_NO_NEST]);
        if (sb.awaited.size() > 0)
            $display("%0d expected responses never arrived", sb.awaited.size());
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("preemptive_priority_task_queue_top_tb: done, clean");
        else
            $display("preemptive_priority_task_queue_top_tb: done, errors");
        $finish;
    end

endmodule
